>>> rtl/auto_exposure_shutter_controller_core_defines.svh
// ----------------------------------------------------------------------------
// Auto-exposure core assertion macros
// Concurrent assertion wrappers shared by the front, queue and back; compiled out when
// ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef AUTO_EXPOSURE_SHUTTER_CONTROLLER_CORE_DEFINES_SVH
`define AUTO_EXPOSURE_SHUTTER_CONTROLLER_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define AESC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed: %m");
`define AESC_ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen: %m");
`else
`define AESC_ASSERT(lbl, clk, rst_n, prop)
`define AESC_ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

>>> rtl/aesc_pkg.sv
// ----------------------------------------------------------------------------
// Auto-exposure core package
// Widths, codes and shared types of the auto-exposure shutter controller.
// ----------------------------------------------------------------------------
`default_nettype none

package aesc_pkg;

  localparam int unsigned MAX_SAMPLES = 65536;

  localparam int unsigned PIX_W  = 8;
  localparam int unsigned MEAN_W = 8;
  localparam int unsigned CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned SUM_W  = $clog2(longint'(MAX_SAMPLES) * 255 + 1);
  // divisor of the mean division, count shifted up to the top quotient bit
  localparam int unsigned DIVS_W = CNT_W + MEAN_W - 1;
  localparam int unsigned CMP_W  = (SUM_W > DIVS_W) ? SUM_W : DIVS_W;

  localparam int unsigned GAINN_W = 20;
  localparam int unsigned GAIN_W  = GAINN_W + 3;
  localparam int unsigned PROD_W  = MEAN_W + GAIN_W;
  localparam int unsigned ITER_W  = $clog2(PROD_W);

  localparam int unsigned SHUT_W = 23;
  localparam int unsigned PEND_W = 32;
  localparam int unsigned NS_W   = PEND_W + 3;

  localparam logic [SHUT_W-1:0] SHUTTER_RESET = SHUT_W'(50000);
  localparam logic [SHUT_W-1:0] SHUTTER_MAX   = {SHUT_W{1'b1}};

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 23;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET_LEVEL = 3'd0,
    CFG_DEADBAND     = 3'd1,
    CFG_SUN_LEVEL    = 3'd2,
    CFG_SHADOW_LEVEL = 3'd3,
    CFG_GAIN_NORMAL  = 3'd4,
    CFG_APPLY_THRESH = 3'd5,
    CFG_MIN_SHUTTER  = 3'd6,
    CFG_MAX_SHUTTER  = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ZONE_NORMAL = 2'd0,
    ZONE_SUN    = 2'd1,
    ZONE_SHADOW = 2'd2
  } zone_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MEAN,
    ST_MUL,
    ST_DIV,
    ST_UPDATE,
    ST_OUT
  } back_state_e;

  // one finished frame as the front hands it to the back
  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] count;
  } frame_t;

  typedef struct packed {
    logic [7:0]         target_level;
    logic [7:0]         deadband;
    logic [7:0]         sun_level;
    logic [7:0]         shadow_level;
    logic [GAINN_W-1:0] gain_normal;
    logic [GAINN_W-1:0] apply_thresh;
    logic [SHUT_W-1:0]  min_shutter;
    logic [SHUT_W-1:0]  max_shutter;
  } cfg_t;

  typedef struct packed {
    logic             empty;
    logic             full;
  } queue_status_t;

endpackage

`default_nettype wire

>>> rtl/aesc_front.sv
// ----------------------------------------------------------------------------
// Auto-exposure front end
// Sums and counts the sampled pixels of a frame and pushes the totals at the
// frame-end beat.
// ----------------------------------------------------------------------------
`default_nettype none
`include "auto_exposure_shutter_controller_core_defines.svh"

module aesc_front
  import aesc_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             accept_i,
  input  wire logic [PIX_W-1:0] pixel_i,
  input  wire logic             sample_i,
  input  wire logic             frame_end_i,
  output frame_t                frame_o,
  output logic                  push_o
);

  logic [SUM_W-1:0] sum_q, sum_d, sum_nx;
  logic [CNT_W-1:0] count_q, count_d, count_nx;
  logic             take;

  // drop samples beyond the per-frame cap
  assign take     = sample_i && (count_q < CNT_W'(MAX_SAMPLES));
  assign sum_nx   = take ? (sum_q + SUM_W'(pixel_i)) : sum_q;
  assign count_nx = take ? (count_q + CNT_W'(1)) : count_q;

  assign push_o        = accept_i && frame_end_i;
  assign frame_o.sum   = sum_nx;
  assign frame_o.count = count_nx;

  always_comb begin
    sum_d   = sum_q;
    count_d = count_q;
    if (accept_i) begin
      if (frame_end_i) begin
        sum_d   = '0;
        count_d = '0;
      end else begin
        sum_d   = sum_nx;
        count_d = count_nx;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      count_q <= '0;
    end else begin
      sum_q   <= sum_d;
      count_q <= count_d;
    end
  end

  `AESC_ASSERT(a_count_capped, clk_i, rst_ni, count_q <= CNT_W'(MAX_SAMPLES))

endmodule

`default_nettype wire

>>> rtl/aesc_queue.sv
// ----------------------------------------------------------------------------
// Auto-exposure frame queue
// Short queue of frame totals between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none
`include "auto_exposure_shutter_controller_core_defines.svh"

module aesc_queue
  import aesc_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   push_i,
  input  wire frame_t data_i,
  input  wire logic   pop_i,
  output frame_t      data_o,
  output queue_status_t status_o
);

  frame_t              entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]   fill_q, fill_d;

  assign status_o.empty = (fill_q == '0);
  assign status_o.full  = (fill_q == QCNT_W'(QUEUE_DEPTH));
  assign data_o         = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
    end
    if (push_i && !pop_i) begin
      fill_d = fill_q + QCNT_W'(1);
    end else if (pop_i && !push_i) begin
      fill_d = fill_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

  `AESC_ASSERT_NEVER(a_no_overflow, clk_i, rst_ni, push_i && status_o.full)
  `AESC_ASSERT_NEVER(a_no_underflow, clk_i, rst_ni, pop_i && status_o.empty)
  `AESC_ASSERT(a_fill_tracks, clk_i, rst_ni, (push_i && !pop_i) |=> !status_o.empty)

endmodule

`default_nettype wire

>>> rtl/aesc_back.sv
// ----------------------------------------------------------------------------
// Auto-exposure back end
// Per frame: restoring mean division, gain multiply, restoring step division,
// then shutter update and registered result beat; empty frames skip to the beat.
// ----------------------------------------------------------------------------
`default_nettype none
`include "auto_exposure_shutter_controller_core_defines.svh"

module aesc_back
  import aesc_pkg::*;
(
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire cfg_t          cfg_i,
  input  wire frame_t        frame_i,
  input  wire queue_status_t q_status_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output logic [SHUT_W-1:0]  shutter_out_o,
  output logic               applied_o,
  output logic [MEAN_W-1:0]  mean_level_o,
  output logic [1:0]         zone_o,
  output logic               held_at_limit_o,
  output logic               empty_frame_o
);

  back_state_e state_q, state_d;

  // control from the output decoder
  logic pop, mean_en, mul_en, div_en, upd_en, load_out, out_free;

  // datapath registers
  logic [SUM_W-1:0]  rem_q;
  logic [DIVS_W-1:0] divs_q;
  logic [MEAN_W-1:0] mean_q;
  logic [ITER_W-1:0] iter_q;
  logic [PROD_W-1:0] prod_q;
  logic [7:0]        drem_q;
  logic              neg_q;
  zone_e             zone_q;
  logic              empty_q, held_q, applied_q;

  logic [SHUT_W-1:0] shutter_q;
  logic [PEND_W-1:0] pending_q;

  logic              out_valid_q;
  logic [SHUT_W-1:0] out_shutter_q;
  logic              out_applied_q, out_held_q, out_empty_q;
  logic [MEAN_W-1:0] out_mean_q;
  zone_e             out_zone_q;

  // ---------------------------------------------------------------- control
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (!q_status_i.empty) begin
          state_d = (frame_i.count == '0) ? ST_OUT : ST_MEAN;
        end
      end
      ST_MEAN: begin
        if (iter_q == '0) state_d = ST_MUL;
      end
      ST_MUL: state_d = ST_DIV;
      ST_DIV: begin
        if (iter_q == '0) state_d = ST_UPDATE;
      end
      ST_UPDATE: state_d = ST_OUT;
      ST_OUT: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    pop      = 1'b0;
    mean_en  = 1'b0;
    mul_en   = 1'b0;
    div_en   = 1'b0;
    upd_en   = 1'b0;
    load_out = 1'b0;
    unique case (state_q)
      ST_IDLE:   pop      = !q_status_i.empty;
      ST_MEAN:   mean_en  = 1'b1;
      ST_MUL:    mul_en   = 1'b1;
      ST_DIV:    div_en   = 1'b1;
      ST_UPDATE: upd_en   = 1'b1;
      ST_OUT:    load_out = out_free;
      default: ;
    endcase
  end

  assign pop_o = pop;

  // -------------------------------------------------------- mean division
  logic [CMP_W-1:0] rem_ext, divs_ext, rem_sub;
  logic             mean_ge;

  assign rem_ext  = CMP_W'(rem_q);
  assign divs_ext = CMP_W'(divs_q);
  assign mean_ge  = rem_ext >= divs_ext;
  assign rem_sub  = rem_ext - divs_ext;

  // ------------------------------------------------------ zone and product
  logic [GAIN_W-1:0] gain_n, gain_c;
  zone_e             zone_c;
  logic              neg_c;
  logic [MEAN_W-1:0] mag_c;
  logic [PROD_W-1:0] prod_c;

  assign gain_n = GAIN_W'(cfg_i.gain_normal);

  always_comb begin
    if (mean_q > cfg_i.sun_level) begin
      zone_c = ZONE_SUN;
      gain_c = (gain_n << 2) + gain_n;
    end else if (mean_q < cfg_i.shadow_level) begin
      zone_c = ZONE_SHADOW;
      gain_c = gain_n << 1;
    end else begin
      zone_c = ZONE_NORMAL;
      gain_c = gain_n;
    end
  end

  assign neg_c  = mean_q > cfg_i.target_level;
  assign mag_c  = neg_c ? (mean_q - cfg_i.target_level) : (cfg_i.target_level - mean_q);
  assign prod_c = (mag_c > cfg_i.deadband) ? (PROD_W'(mag_c) * PROD_W'(gain_c)) : '0;

  // ------------------------------------------------------- step division
  logic [7:0] den;
  logic [8:0] drem_sh, drem_sub;
  logic       div_ge;

  assign den      = (cfg_i.target_level == 8'd255) ? 8'd1 : (8'd255 - cfg_i.target_level);
  assign drem_sh  = {drem_q, prod_q[PROD_W-1]};
  assign div_ge   = drem_sh >= {1'b0, den};
  assign drem_sub = drem_sh - {1'b0, den};

  // --------------------------------------------------------------- update
  logic                     q_zero, held_c, pmag_lt, apply_c;
  logic [PEND_W:0]          step_mag, pmag, lim_x;
  logic signed [PEND_W:0]   pend_x, step_x, pend_sum;
  logic [PEND_W-1:0]        pend_sat;
  logic signed [NS_W-1:0]   ns, min_x, max_x;
  logic [SHUT_W-1:0]        ns_clamp;

  assign q_zero = (prod_q == '0);
  assign held_c = ((!neg_q || q_zero) && (shutter_q >= cfg_i.max_shutter)) ||
                  ((neg_q || q_zero) && (shutter_q <= cfg_i.min_shutter));

  assign step_mag = (PEND_W+1)'(prod_q);
  assign step_x   = neg_q ? -step_mag : step_mag;
  assign pend_x   = {pending_q[PEND_W-1], pending_q};
  assign pmag     = pend_x[PEND_W] ? -pend_x : pend_x;
  assign lim_x    = (PEND_W+1)'(cfg_i.apply_thresh);
  assign pmag_lt  = pmag < lim_x;
  assign apply_c  = !held_c && !pmag_lt;

  // saturate the pending sum at the signed 32-bit range
  assign pend_sum = pend_x + step_x;
  always_comb begin
    if (pend_sum[PEND_W] != pend_sum[PEND_W-1]) begin
      pend_sat = pend_sum[PEND_W] ? {1'b1, {(PEND_W-1){1'b0}}} : {1'b0, {(PEND_W-1){1'b1}}};
    end else begin
      pend_sat = pend_sum[PEND_W-1:0];
    end
  end

  assign ns    = $signed({{(NS_W-SHUT_W){1'b0}}, shutter_q})
               + $signed({{2{pend_x[PEND_W]}}, pend_x})
               + $signed({{2{step_x[PEND_W]}}, step_x});
  assign min_x = $signed({{(NS_W-SHUT_W){1'b0}}, cfg_i.min_shutter});
  assign max_x = $signed({{(NS_W-SHUT_W){1'b0}}, SHUTTER_MAX});

  always_comb begin
    if (ns < min_x) begin
      ns_clamp = cfg_i.min_shutter;
    end else if (ns > max_x) begin
      ns_clamp = SHUTTER_MAX;
    end else begin
      ns_clamp = ns[SHUT_W-1:0];
    end
  end

  // ------------------------------------------------------------ registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      shutter_q   <= SHUTTER_RESET;
      pending_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (upd_en && !held_c) begin
        if (pmag_lt) begin
          pending_q <= pend_sat;
        end else begin
          shutter_q <= ns_clamp;
          pending_q <= '0;
        end
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      rem_q     <= frame_i.sum;
      divs_q    <= DIVS_W'(frame_i.count) << (MEAN_W - 1);
      iter_q    <= ITER_W'(MEAN_W - 1);
      mean_q    <= '0;
      zone_q    <= ZONE_NORMAL;
      held_q    <= 1'b0;
      applied_q <= 1'b0;
      empty_q   <= (frame_i.count == '0);
    end
    if (mean_en) begin
      if (mean_ge) rem_q <= rem_sub[SUM_W-1:0];
      mean_q <= {mean_q[MEAN_W-2:0], mean_ge};
      divs_q <= divs_q >> 1;
      iter_q <= iter_q - ITER_W'(1);
    end
    if (mul_en) begin
      prod_q <= prod_c;
      neg_q  <= neg_c;
      zone_q <= zone_c;
      drem_q <= '0;
      iter_q <= ITER_W'(PROD_W - 1);
    end
    if (div_en) begin
      drem_q <= div_ge ? drem_sub[7:0] : drem_sh[7:0];
      prod_q <= {prod_q[PROD_W-2:0], div_ge};
      iter_q <= iter_q - ITER_W'(1);
    end
    if (upd_en) begin
      held_q    <= held_c;
      applied_q <= apply_c;
    end
    if (load_out) begin
      out_shutter_q <= shutter_q;
      out_applied_q <= applied_q;
      out_mean_q    <= mean_q;
      out_zone_q    <= zone_q;
      out_held_q    <= held_q;
      out_empty_q   <= empty_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign shutter_out_o   = out_shutter_q;
  assign applied_o       = out_applied_q;
  assign mean_level_o    = out_mean_q;
  assign zone_o          = out_zone_q;
  assign held_at_limit_o = out_held_q;
  assign empty_frame_o   = out_empty_q;

  `AESC_ASSERT(a_apply_clears, clk_i, rst_ni, (upd_en && apply_c) |=> (pending_q == '0 && applied_q))
  `AESC_ASSERT(a_load_sets_valid, clk_i, rst_ni, load_out |=> out_valid_q)

endmodule

`default_nettype wire

>>> rtl/auto_exposure_shutter_controller_core.sv
// ----------------------------------------------------------------------------
// Auto-exposure shutter controller core
// Averages the sampled pixels of each frame and steers the shutter time
// toward the target level.
// ----------------------------------------------------------------------------
//  channel  direction  handshake                 payload
//  in       sink       in_valid_i / in_stall_o   pixel_i, sample_i, frame_end_i
//  out      source     out_valid_o / out_stall_i shutter_out_o, applied_o,
//                                                mean_level_o, zone_o,
//                                                held_at_limit_o, empty_frame_o
//  cfg      sink       cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
//  Pixels are taken one per cycle; the front end only stalls while the
//  two-entry frame queue is full.
//  Each non-empty frame passes the back end through the mean division, the
//  gain multiply and the step division (one quotient bit per cycle), then the
//  update and the result beat; an empty frame goes straight to the result beat.
//  Reset restores the register defaults and a shutter time of 50000.
//  A stalled result holds in the output register; the back end waits behind it.
// ----------------------------------------------------------------------------
`default_nettype none

module auto_exposure_shutter_controller_core
  import aesc_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [PIX_W-1:0]      pixel_i,
  input  wire logic                  sample_i,
  input  wire logic                  frame_end_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic [SHUT_W-1:0]          shutter_out_o,
  output logic                       applied_o,
  output logic [MEAN_W-1:0]          mean_level_o,
  output logic [1:0]                 zone_o,
  output logic                       held_at_limit_o,
  output logic                       empty_frame_o,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t          cfg_q;
  frame_t        push_frame, head_frame;
  logic          push, pop, in_accept;
  queue_status_t q_status;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = q_status.full;
  assign in_accept   = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target_level <= 8'd90;
      cfg_q.deadband     <= 8'd13;
      cfg_q.sun_level    <= 8'd130;
      cfg_q.shadow_level <= 8'd70;
      cfg_q.gain_normal  <= GAINN_W'(9000);
      cfg_q.apply_thresh <= GAINN_W'(1000);
      cfg_q.min_shutter  <= SHUT_W'(10000);
      cfg_q.max_shutter  <= SHUT_W'(2499000);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_TARGET_LEVEL: cfg_q.target_level <= cfg_data_i[7:0];
        CFG_DEADBAND:     cfg_q.deadband     <= cfg_data_i[7:0];
        CFG_SUN_LEVEL:    cfg_q.sun_level    <= cfg_data_i[7:0];
        CFG_SHADOW_LEVEL: cfg_q.shadow_level <= cfg_data_i[7:0];
        CFG_GAIN_NORMAL:  cfg_q.gain_normal  <= cfg_data_i[GAINN_W-1:0];
        CFG_APPLY_THRESH: cfg_q.apply_thresh <= cfg_data_i[GAINN_W-1:0];
        CFG_MIN_SHUTTER:  cfg_q.min_shutter  <= cfg_data_i[SHUT_W-1:0];
        CFG_MAX_SHUTTER:  cfg_q.max_shutter  <= cfg_data_i[SHUT_W-1:0];
        default: ;
      endcase
    end
  end

  aesc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_accept),
    .pixel_i     (pixel_i),
    .sample_i    (sample_i),
    .frame_end_i (frame_end_i),
    .frame_o     (push_frame),
    .push_o      (push)
  );

  aesc_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .data_i   (push_frame),
    .pop_i    (pop),
    .data_o   (head_frame),
    .status_o (q_status)
  );

  aesc_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .frame_i         (head_frame),
    .q_status_i      (q_status),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .shutter_out_o   (shutter_out_o),
    .applied_o       (applied_o),
    .mean_level_o    (mean_level_o),
    .zone_o          (zone_o),
    .held_at_limit_o (held_at_limit_o),
    .empty_frame_o   (empty_frame_o)
  );

endmodule

`default_nettype wire
